// ===== src/rgd_pkg.sv =====
// Shared types, constants and register codes of the gadget decomposition block.
`default_nettype none

package rgd_pkg;

  localparam int MAX_DIGITS = 64;
  localparam int ROW_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = ROW_W + 1;
  localparam int RES_W      = 62;
  localparam int WORD_W     = 64;
  localparam int WIDE_W     = 2 * WORD_W;
  localparam int BITS_W     = 6;
  localparam int NUM_BANKS  = 2;
  localparam int RAM_DEPTH  = NUM_BANKS * MAX_DIGITS;
  localparam int RAM_AW     = $clog2(RAM_DEPTH);
  localparam int NUM_REGS   = 8;
  localparam int ADDR_W     = $clog2(8 * NUM_REGS);
  localparam int DATA_W     = 64;

  localparam logic [2:0] REG_MODULUS_A   = 3'd0;
  localparam logic [2:0] REG_MODULUS_B   = 3'd1;
  localparam logic [2:0] REG_INVERSE     = 3'd2;
  localparam logic [2:0] REG_POW64_A     = 3'd3;
  localparam logic [2:0] REG_POW64_B     = 3'd4;
  localparam logic [2:0] REG_DIGIT_BITS  = 3'd5;
  localparam logic [2:0] REG_DIGIT_COUNT = 3'd6;
  localparam logic [2:0] REG_TWO_MODULI  = 3'd7;

  typedef struct packed {
    logic [RES_W-1:0] residue_a;
    logic [RES_W-1:0] residue_b;
  } coef_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [RES_W-1:0] digit_res_a;
    logic [RES_W-1:0] digit_res_b;
    logic             last_digit;
  } digit_t;

  // effective settings: bits never zero, count saturated to MAX_DIGITS
  typedef struct packed {
    logic [RES_W-1:0]  mod_a;
    logic [RES_W-1:0]  mod_b;
    logic [RES_W-1:0]  inv;
    logic [BITS_W-1:0] bits;
    logic [CNT_W-1:0]  count;
    logic              crt;
  } cfg_t;

  // classified word: centered value in single mode, raw residues in CRT mode
  typedef struct packed {
    logic              crt;
    logic [WORD_W-1:0] val_a;
    logic [RES_W-1:0]  val_b;
  } item_t;

  typedef struct packed {
    logic [RES_W-1:0] res_a;
    logic [RES_W-1:0] res_b;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    entry_t            data;
  } wr_t;

endpackage

`default_nettype wire

// ===== src/rgd_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module rgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/rgd_rem.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`default_nettype none

module rgd_rem
  import rgd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [RES_W-1:0]  modulus,
  output logic                   busy,
  output logic      [WORD_W-1:0] result
);

  logic [RES_W-1:0]  rem;
  logic [WORD_W-1:0] dvd;
  logic [RES_W-1:0]  mod;
  logic [ROW_W-1:0]  step;
  logic [RES_W:0]    cand;
  logic [RES_W:0]    rem_next;

  always_comb begin
    cand = {rem, dvd[WORD_W-1]};
    if (cand >= {1'b0, mod}) begin
      rem_next = cand - {1'b0, mod};
    end else begin
      rem_next = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      if (modulus == '0) begin
        // reduction by zero leaves the operand as is
        busy   <= 1'b0;
        result <= dividend;
      end else begin
        busy <= 1'b1;
        rem  <= '0;
        dvd  <= dividend;
        mod  <= modulus;
        step <= '0;
      end
    end else if (busy) begin
      rem  <= rem_next[RES_W-1:0];
      dvd  <= dvd << 1;
      step <= step + ROW_W'(1);
      if (step == ROW_W'(WORD_W - 1)) begin
        busy   <= 1'b0;
        result <= {{(WORD_W - RES_W){1'b0}}, rem_next[RES_W-1:0]};
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/rgd_front.sv =====
// Input side: takes coefficient words, centers or passes them, two-entry queue.
`default_nettype none

module rgd_front
  import rgd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  coef_valid,
  output logic       coef_stall,
  input  wire coef_t coef,
  output logic       q_valid,
  output item_t      q_item,
  input  wire logic  q_pop
);

  item_t      slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;
  item_t      cls;
  logic [WORD_W-1:0] ra_ext;

  assign coef_stall = (count == 2'd2);
  assign push       = coef_valid && !coef_stall;
  assign q_valid    = (count != 2'd0);
  assign q_item     = slots[rp];

  always_comb begin
    ra_ext    = {{(WORD_W - RES_W){1'b0}}, coef.residue_a};
    cls.crt   = cfg.crt;
    cls.val_b = coef.residue_b;
    cls.val_a = ra_ext;
    // single mode: center into (-q/2, q/2] as a two's complement word
    if (!cfg.crt && (coef.residue_a > {1'b0, cfg.mod_a[RES_W-1:1]})) begin
      cls.val_a = ra_ext - {{(WORD_W - RES_W){1'b0}}, cfg.mod_a};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        slots[wp] <= cls;
        wp        <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

`default_nettype wire

// ===== src/rgd_engine.sv =====
// Digit engine: signed digit peeling or CRT join, writes digits into a RAM bank.
`default_nettype none

module rgd_engine
  import rgd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire logic                 q_valid,
  input  wire item_t                q_item,
  output logic                      q_pop,
  output wr_t                       wr,
  output logic      [NUM_BANKS-1:0] bank_full,
  input  wire logic [NUM_BANKS-1:0] bank_free
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SIG    = 3'd1;
  localparam logic [2:0] S_RED1   = 3'd2;
  localparam logic [2:0] S_RED2   = 3'd3;
  localparam logic [2:0] S_MM     = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_DSTART = 3'd6;
  localparam logic [2:0] S_DWAIT  = 3'd7;

  localparam logic [2:0] PP_LAST = 3'd4;
  localparam logic [2:0] PP_DONE = 3'd5;

  logic [2:0]        state;
  logic              wbank;
  logic [ROW_W-1:0]  idx;
  logic [WORD_W-1:0] d;
  logic [RES_W-1:0]  ra_hold;
  logic [WIDE_W-1:0] x;
  logic [RES_W-1:0]  mm_a;
  logic [RES_W-1:0]  mm_b;
  logic [RES_W-1:0]  mm_acc;
  logic [WORD_W-1:0] opa;
  logic [WORD_W-1:0] opb;
  logic [WORD_W-1:0] pp;
  logic [1:0]        pp_sh;
  logic [2:0]        pp_cnt;
  logic              mul_ph;

  logic [WORD_W-1:0] mask64;
  logic              sbit;
  logic [WORD_W-1:0] r;
  logic [WORD_W-1:0] t;
  logic [WORD_W-1:0] d_next;
  logic [WORD_W-1:0] dig;
  logic              last;
  logic              finish;
  logic              finish_sig;
  logic              tgt_bank;
  logic              take;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] diff;
  logic [RES_W:0]    acc_sum;
  logic [RES_W:0]    acc_red;
  logic [RES_W:0]    dbl;
  logic [RES_W:0]    dbl_red;
  logic [1:0]        part;
  logic [31:0]       ah;
  logic [31:0]       bh;
  logic [WORD_W-1:0] prod;
  logic [WIDE_W-1:0] pp_shifted;

  logic              start0;
  logic              start1;
  logic [WORD_W-1:0] dvd0;
  logic [WORD_W-1:0] dvd1;
  logic [RES_W-1:0]  m0;
  logic [RES_W-1:0]  m1;
  logic              r0_busy;
  logic              r1_busy;
  logic [WORD_W-1:0] r0_res;
  logic [WORD_W-1:0] r1_res;
  logic              rems_idle;

  assign rems_idle = !r0_busy && !r1_busy;

  // balanced digit step: sign-extend low bits, subtract, arithmetic shift
  always_comb begin
    mask64 = (WORD_W'(1) << cfg.bits) - WORD_W'(1);
    sbit   = d[cfg.bits - BITS_W'(1)];
    r      = d & mask64;
    if (sbit) begin
      r = r | ~mask64;
    end
    t      = d - r;
    d_next = $signed(t) >>> cfg.bits;
    dig    = r[WORD_W-1] ? r + {{(WORD_W - RES_W){1'b0}}, cfg.mod_a} : r;
  end

  assign last       = ({1'b0, idx} == cfg.count - CNT_W'(1));
  assign finish_sig = (state == S_SIG) && last;
  assign finish     = wr.en && last;
  assign tgt_bank   = finish_sig ? ~wbank : wbank;
  // a bank whose last entry is read this cycle can be refilled from the next one
  assign take       = q_valid && ((state == S_IDLE) || finish_sig) &&
                      (!bank_full[tgt_bank] || bank_free[tgt_bank]);
  assign q_pop      = take;

  always_comb begin
    wr.en   = (state == S_SIG) || ((state == S_DWAIT) && rems_idle);
    wr.addr = {wbank, idx};
    if (state == S_SIG) begin
      wr.data.res_a = dig[RES_W-1:0];
      wr.data.res_b = '0;
    end else begin
      wr.data.res_a = r0_res[RES_W-1:0];
      wr.data.res_b = r1_res[RES_W-1:0];
    end
  end

  // CRT difference (r_b - r_a) mod q_b from the two reduced residues
  always_comb begin
    sum  = r1_res + {{(WORD_W - RES_W){1'b0}}, cfg.mod_b} - r0_res;
    diff = sum;
    if ((cfg.mod_b != '0) && (sum >= {{(WORD_W - RES_W){1'b0}}, cfg.mod_b})) begin
      diff = sum - {{(WORD_W - RES_W){1'b0}}, cfg.mod_b};
    end
  end

  // shift-and-add modular product, one multiplier bit per cycle
  always_comb begin
    acc_sum = {1'b0, mm_acc} + {1'b0, mm_a};
    acc_red = (acc_sum >= {1'b0, cfg.mod_b}) ? acc_sum - {1'b0, cfg.mod_b} : acc_sum;
    dbl     = {1'b0, mm_a} + {1'b0, mm_a};
    dbl_red = (dbl >= {1'b0, cfg.mod_b}) ? dbl - {1'b0, cfg.mod_b} : dbl;
  end

  // 64x64 product as four 32x32 partial products
  always_comb begin
    part = pp_cnt[1:0];
    ah   = part[1] ? opa[WORD_W-1:32] : opa[31:0];
    bh   = part[0] ? opb[WORD_W-1:32] : opb[31:0];
    prod = WORD_W'(ah) * WORD_W'(bh);
    case (pp_sh)
      2'd0:    pp_shifted = {{WORD_W{1'b0}}, pp};
      2'd1:    pp_shifted = {32'b0, pp, 32'b0};
      default: pp_shifted = {pp, {WORD_W{1'b0}}};
    endcase
  end

  always_comb begin
    start0 = 1'b0;
    start1 = 1'b0;
    dvd0   = {{(WORD_W - RES_W){1'b0}}, q_item.val_a[RES_W-1:0]};
    dvd1   = {{(WORD_W - RES_W){1'b0}}, q_item.val_b};
    m0     = cfg.mod_b;
    m1     = cfg.mod_b;
    if (take && q_item.crt && (cfg.count != '0)) begin
      start0 = 1'b1;
      start1 = 1'b1;
    end else if ((state == S_RED1) && rems_idle && (cfg.mod_b != '0)) begin
      start0 = 1'b1;
      dvd0   = {{(WORD_W - RES_W){1'b0}}, cfg.inv};
    end else if (state == S_DSTART) begin
      start0 = 1'b1;
      start1 = 1'b1;
      dvd0   = x[WORD_W-1:0] & mask64;
      dvd1   = x[WORD_W-1:0] & mask64;
      m0     = cfg.mod_a;
    end
  end

  rgd_rem u_rem0 (
    .clk      (clk),
    .rst      (rst),
    .start    (start0),
    .dividend (dvd0),
    .modulus  (m0),
    .busy     (r0_busy),
    .result   (r0_res)
  );

  rgd_rem u_rem1 (
    .clk      (clk),
    .rst      (rst),
    .start    (start1),
    .dividend (dvd1),
    .modulus  (m1),
    .busy     (r1_busy),
    .result   (r1_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wbank     <= 1'b0;
      bank_full <= '0;
    end else begin
      bank_full <= (bank_full & ~bank_free) |
                   (finish ? (NUM_BANKS'(1) << wbank) : NUM_BANKS'(0));
      if (finish) begin
        wbank <= ~wbank;
      end
      case (state)
        S_IDLE: begin
        end
        S_SIG: begin
          d   <= d_next;
          idx <= idx + ROW_W'(1);
          if (last) begin
            state <= S_IDLE;
          end
        end
        S_RED1: begin
          if (rems_idle) begin
            if (cfg.mod_b == '0) begin
              // plain product, low word kept
              opa    <= diff;
              opb    <= {{(WORD_W - RES_W){1'b0}}, cfg.inv};
              x      <= '0;
              mul_ph <= 1'b0;
              pp_cnt <= '0;
              state  <= S_MUL;
            end else begin
              mm_a   <= diff[RES_W-1:0];
              mm_acc <= '0;
              state  <= S_RED2;
            end
          end
        end
        S_RED2: begin
          if (!r0_busy) begin
            mm_b  <= r0_res[RES_W-1:0];
            state <= S_MM;
          end
        end
        S_MM: begin
          if (mm_b == '0) begin
            opa    <= {{(WORD_W - RES_W){1'b0}}, cfg.mod_a};
            opb    <= {{(WORD_W - RES_W){1'b0}}, mm_acc};
            x      <= {{(WIDE_W - RES_W){1'b0}}, ra_hold};
            mul_ph <= 1'b1;
            pp_cnt <= '0;
            state  <= S_MUL;
          end else begin
            if (mm_b[0]) begin
              mm_acc <= acc_red[RES_W-1:0];
            end
            mm_a <= dbl_red[RES_W-1:0];
            mm_b <= mm_b >> 1;
          end
        end
        S_MUL: begin
          pp     <= prod;
          pp_sh  <= {1'b0, part[1]} + {1'b0, part[0]};
          pp_cnt <= pp_cnt + 3'd1;
          if ((pp_cnt != 3'd0) && (pp_cnt <= PP_LAST)) begin
            x <= x + pp_shifted;
          end
          if (pp_cnt == PP_DONE) begin
            if (!mul_ph) begin
              opa    <= {{(WORD_W - RES_W){1'b0}}, cfg.mod_a};
              opb    <= x[WORD_W-1:0];
              x      <= {{(WIDE_W - RES_W){1'b0}}, ra_hold};
              mul_ph <= 1'b1;
              pp_cnt <= '0;
            end else begin
              idx   <= '0;
              state <= S_DSTART;
            end
          end
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (rems_idle) begin
            x   <= x >> cfg.bits;
            idx <= idx + ROW_W'(1);
            state <= last ? S_IDLE : S_DSTART;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (take) begin
        idx     <= '0;
        d       <= q_item.val_a;
        ra_hold <= q_item.val_a[RES_W-1:0];
        if (cfg.count == '0) begin
          state <= S_IDLE;
        end else if (q_item.crt) begin
          state <= S_RED1;
        end else begin
          state <= S_SIG;
        end
      end
    end
  end

  a_wr_free_bank: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !bank_full[wr.addr[RAM_AW-1]])
    else $error("digit write into a bank still being emitted");

  a_take_rems_idle: assert property (@(posedge clk) disable iff (rst)
    take |-> rems_idle)
    else $error("new word taken while a remainder unit is busy");

endmodule

`default_nettype wire

// ===== src/rgd_emit.sv =====
// Emitter: reads a full bank in reverse, two-entry output queue.
`default_nettype none

module rgd_emit
  import rgd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire logic [NUM_BANKS-1:0] bank_full,
  output logic      [NUM_BANKS-1:0] bank_free,
  output logic                      rd_en,
  output logic      [RAM_AW-1:0]    rd_addr,
  input  wire entry_t               rd_data,
  output logic                      digit_valid,
  input  wire logic                 digit_stall,
  output digit_t                    digit
);

  logic             rbank;
  logic [ROW_W-1:0] row;
  logic             fl;
  logic [ROW_W-1:0] fl_row;
  logic             fl_last;
  digit_t           fifo [2];
  logic             fwr;
  logic             frd;
  logic [1:0]       fcount;
  logic             pop;
  logic             last;
  logic [CNT_W-1:0] rd_idx;

  assign pop         = digit_valid && !digit_stall;
  assign digit_valid = (fcount != 2'd0);
  assign digit       = fifo[frd];
  assign last        = ({1'b0, row} == cfg.count - CNT_W'(1));
  assign rd_idx      = cfg.count - CNT_W'(1) - {1'b0, row};
  assign rd_addr     = {rbank, rd_idx[ROW_W-1:0]};

  // queue slots plus the read in flight must leave room
  assign rd_en = bank_full[rbank] &&
                 (({1'b0, fcount} + {2'b0, fl}) < (3'd2 + {2'b0, pop}));
  assign bank_free = (rd_en && last) ? (NUM_BANKS'(1) << rbank) : NUM_BANKS'(0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rbank  <= 1'b0;
      row    <= '0;
      fl     <= 1'b0;
      fwr    <= 1'b0;
      frd    <= 1'b0;
      fcount <= 2'd0;
    end else begin
      fl <= rd_en;
      if (rd_en) begin
        fl_row  <= row;
        fl_last <= last;
        if (last) begin
          row   <= '0;
          rbank <= ~rbank;
        end else begin
          row <= row + ROW_W'(1);
        end
      end
      if (fl) begin
        fifo[fwr].row_index   <= fl_row;
        fifo[fwr].digit_res_a <= rd_data.res_a;
        fifo[fwr].digit_res_b <= rd_data.res_b;
        fifo[fwr].last_digit  <= fl_last;
        fwr                   <= ~fwr;
      end
      if (pop) begin
        frd <= ~frd;
      end
      fcount <= fcount + {1'b0, fl} - {1'b0, pop};
    end
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fcount != 2'd3)
    else $error("output queue overflow");

  a_free_only_full: assert property (@(posedge clk) disable iff (rst)
    (bank_free != '0) |-> ((bank_free & bank_full) == bank_free))
    else $error("release of a bank that is not full");

endmodule

`default_nettype wire

// ===== src/rns_gadget_decompose.sv =====
// Top level of the RNS gadget decomposition block: registers, queue, engine, emitter.
// Single mode: a word is accepted, peeled one digit per cycle into a bank of the digit RAM,
//   and its digits come out one per cycle while the receiver does not stall; the next word
//   is taken as the last digit is written if a bank is free: the two banks overlap peeling with emission.
// Two-moduli mode: each word goes through the bit-serial remainder units and the modular
//   product; the next word is taken only after the last digit of the word is written.
// Reset (rst, synchronous): registers to defaults, queues and banks empty; no RAM clearing.
`default_nettype none

module rns_gadget_decompose
  import rgd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              coef_valid,
  output logic                   coef_stall,
  input  wire coef_t             coef,
  output logic                   digit_valid,
  input  wire logic              digit_stall,
  output digit_t                 digit
);

  logic [RES_W-1:0]  modulus_a;
  logic [RES_W-1:0]  modulus_b;
  logic [RES_W-1:0]  inverse_a_mod_b;
  logic [RES_W-1:0]  pow64_mod_a;
  logic [RES_W-1:0]  pow64_mod_b;
  logic [BITS_W-1:0] digit_bits;
  logic [CNT_W-1:0]  digit_count;
  logic              two_moduli;

  logic                 reg_wr;
  logic [2:0]           reg_sel;
  cfg_t                 cfg;
  logic                 q_valid;
  item_t                q_item;
  logic                 q_pop;
  wr_t                  wr;
  logic [NUM_BANKS-1:0] bank_full;
  logic [NUM_BANKS-1:0] bank_free;
  logic                 rd_en;
  logic [RAM_AW-1:0]    rd_addr;
  entry_t               rd_data;

  // register file, 8-byte stride
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_a       <= RES_W'(2);
      modulus_b       <= RES_W'(3);
      inverse_a_mod_b <= RES_W'(1);
      pow64_mod_a     <= '0;
      pow64_mod_b     <= '0;
      digit_bits      <= BITS_W'(16);
      digit_count     <= CNT_W'(4);
      two_moduli      <= 1'b0;
    end else if (reg_wr) begin
      case (reg_sel)
        REG_MODULUS_A:   modulus_a       <= pwdata[RES_W-1:0];
        REG_MODULUS_B:   modulus_b       <= pwdata[RES_W-1:0];
        REG_INVERSE:     inverse_a_mod_b <= pwdata[RES_W-1:0];
        REG_POW64_A:     pow64_mod_a     <= pwdata[RES_W-1:0];
        REG_POW64_B:     pow64_mod_b     <= pwdata[RES_W-1:0];
        REG_DIGIT_BITS:  digit_bits      <= pwdata[BITS_W-1:0];
        REG_DIGIT_COUNT: digit_count     <= pwdata[CNT_W-1:0];
        REG_TWO_MODULI:  two_moduli      <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MODULUS_A:   prdata = DATA_W'(modulus_a);
      REG_MODULUS_B:   prdata = DATA_W'(modulus_b);
      REG_INVERSE:     prdata = DATA_W'(inverse_a_mod_b);
      REG_POW64_A:     prdata = DATA_W'(pow64_mod_a);
      REG_POW64_B:     prdata = DATA_W'(pow64_mod_b);
      REG_DIGIT_BITS:  prdata = DATA_W'(digit_bits);
      REG_DIGIT_COUNT: prdata = DATA_W'(digit_count);
      REG_TWO_MODULI:  prdata = DATA_W'(two_moduli);
      default:         prdata = '0;
    endcase
  end

  // effective settings: zero digit width acts as one, count capped at the bank depth.
  // The 2^64 residues are kept for readback only: every digit fits in one word.
  always_comb begin
    cfg.mod_a = modulus_a;
    cfg.mod_b = modulus_b;
    cfg.inv   = inverse_a_mod_b;
    cfg.bits  = (digit_bits == '0) ? BITS_W'(1) : digit_bits;
    cfg.count = (digit_count > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : digit_count;
    cfg.crt   = two_moduli;
  end

  rgd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .coef_valid (coef_valid),
    .coef_stall (coef_stall),
    .coef       (coef),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  rgd_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .wr        (wr),
    .bank_full (bank_full),
    .bank_free (bank_free)
  );

  // two banks of MAX_DIGITS entries: one fills while the other drains
  rgd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rgd_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .bank_full   (bank_full),
    .bank_free   (bank_free),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall),
    .digit       (digit)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the RNS gadget decomposition block.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rgd_pkg::*;

  localparam int LIMIT = 8_000_000;
  localparam logic [63:0] MAX62 = (64'd1 << 62) - 64'd1;

  // Expected-digit store and gadget predictor with its own register copy.
  class digit_scoreboard;
    logic [RES_W-1:0]  mod_a = 62'd2, mod_b = 62'd3, inv = 62'd1, pow_a = '0, pow_b = '0;
    logic [BITS_W-1:0] bits = 6'd16;
    logic [CNT_W-1:0]  count = 7'd4;
    logic              crt = 1'b0;
    digit_t            pending_digits[$];
    int                errors = 0;
    int                checked = 0;
    int                coefs = 0;

    function void write_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        REG_MODULUS_A:   mod_a = v[61:0];
        REG_MODULUS_B:   mod_b = v[61:0];
        REG_INVERSE:     inv   = v[61:0];
        REG_POW64_A:     pow_a = v[61:0];
        REG_POW64_B:     pow_b = v[61:0];
        REG_DIGIT_BITS:  bits  = v[5:0];
        REG_DIGIT_COUNT: count = v[6:0];
        default:         crt   = v[0];
      endcase
    endfunction

    function logic [63:0] red(logic [63:0] x, logic [63:0] m);
      return (m == 0) ? x : x % m;
    endfunction

    function logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] p;
      if (m == 0) return a * b;
      p = {64'd0, a % m} * {64'd0, b % m};
      return 64'(p % {64'd0, m});
    endfunction

    // compute all digits of one accepted coefficient
    function void note_coef(coef_t c);
      logic [63:0] store[MAX_DIGITS];
      logic [63:0] q, d, r, t, mask, ra, rb, q1, diff, s, v;
      logic [127:0] x;
      int b, l, sh;
      digit_t e;
      coefs++;
      b = (bits == 0) ? 1 : int'(bits);
      l = (count > 64) ? 64 : int'(count);
      mask = (64'd1 << b) - 64'd1;
      ra = {2'b0, c.residue_a};
      rb = {2'b0, c.residue_b};
      if (!crt) begin
        q = {2'b0, mod_a};
        d = (ra > (q >> 1)) ? ra - q : ra;
        for (int i = 0; i < l; i++) begin
          r = d & mask;
          if (r[b-1]) r = r | ~mask;   // negative balanced digit
          t = d - r;
          d = 64'($signed(t) >>> b);
          store[i] = r[63] ? r + q : r;
        end
      end else begin
        q1 = {2'b0, mod_b};
        diff = red(red(rb, q1) + q1 - red(ra, q1), q1);
        s = mod_mul(diff, {2'b0, inv}, q1);
        x = {64'd0, 2'b0, mod_a} * {64'd0, s} + {64'd0, ra};
        for (int i = 0; i < l; i++) begin
          sh = i * b;
          v = (sh >= 128) ? 64'd0 : 64'(x >> sh);
          store[i] = v & mask;
        end
      end
      for (int row = 0; row < l; row++) begin
        v = store[l-1-row];
        e.row_index = row[5:0];
        if (crt) begin
          e.digit_res_a = 62'(red(v, {2'b0, mod_a}));
          e.digit_res_b = 62'(red(v, {2'b0, mod_b}));
        end else begin
          e.digit_res_a = v[61:0];
          e.digit_res_b = '0;
        end
        e.last_digit = (row == l - 1);
        pending_digits = {pending_digits, e};
      end
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task check_digit(digit_t got);
      digit_t e;
      checked++;
      if (pending_digits.size() == 0) begin
        report($sformatf("unexpected word row %0d", got.row_index));
        return;
      end
      e = pending_digits.pop_front();
      if (got.row_index !== e.row_index)
        report($sformatf("row_index %0d want %0d", got.row_index, e.row_index));
      if (got.digit_res_a !== e.digit_res_a)
        report($sformatf("row %0d digit_res_a %h want %h", e.row_index,
                         got.digit_res_a, e.digit_res_a));
      if (got.digit_res_b !== e.digit_res_b)
        report($sformatf("row %0d digit_res_b %h want %h", e.row_index,
                         got.digit_res_b, e.digit_res_b));
      if (got.last_digit !== e.last_digit)
        report($sformatf("row %0d last_digit %b want %b", e.row_index,
                         got.last_digit, e.last_digit));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              coef_valid = 1'b0;
  logic              coef_stall;
  coef_t             coef = '0;
  logic              digit_valid;
  logic              digit_stall = 1'b0;
  digit_t            digit;

  digit_scoreboard sb = new();
  int idle_pct  = 0;   // sender gap chance, percent
  int stall_pct = 0;   // receiver stall chance, percent
  int cycles = 0;
  int phases = 0;

  rns_gadget_decompose dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .coef_valid(coef_valid), .coef_stall(coef_stall), .coef(coef),
    .digit_valid(digit_valid), .digit_stall(digit_stall), .digit(digit)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("rns_gadget_decompose verification failed");
      $finish;
    end
  end

  // receiver: stall decided at falling edge, word taken at rising edge
  always @(negedge clk) begin
    digit_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && digit_valid && !digit_stall) sb.check_digit(digit);
  end

  function logic [61:0] rand62();
    return 62'({$urandom, $urandom});
  endfunction

  // APB write; register i sits at byte address 8*i
  task write_reg(logic [2:0] idx, logic [63:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 3'b000}); pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task set_config(logic [61:0] ma, logic [61:0] mb, logic [5:0] b, logic [6:0] l,
                  logic crt);
    write_reg(REG_MODULUS_A, {2'b0, ma});
    write_reg(REG_MODULUS_B, {2'b0, mb});
    write_reg(REG_INVERSE, {2'b0, rand62()});
    write_reg(REG_POW64_A, {2'b0, rand62()});
    write_reg(REG_POW64_B, {$urandom, $urandom});   // upper bits dropped by the register
    write_reg(REG_DIGIT_BITS, {58'd0, b});
    write_reg(REG_DIGIT_COUNT, {57'd0, l});
    write_reg(REG_TWO_MODULI, {63'd0, crt});
  endtask

  // offer one word; returns once it is accepted
  task send_coef(coef_t c);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      coef_valid <= 1'b0;
      @(negedge clk);
    end
    coef_valid <= 1'b1;
    coef <= c;
    do @(posedge clk); while (coef_stall);
    sb.note_coef(c);
  endtask

  // residue mix: full range, in range of the modulus, and edge values
  function logic [61:0] pick_residue(logic [61:0] m);
    int k;
    k = $urandom_range(9);
    if (k < 5) return rand62();
    if (k < 8) return (m == 0) ? rand62() : rand62() % m;
    case ($urandom_range(4))
      0: return '0;
      1: return m - 62'd1;
      2: return m >> 1;
      3: return (m >> 1) + 62'd1;
      default: return MAX62[61:0];
    endcase
  endfunction

  // drain and let the engine settle (zero-count words leave no trace)
  task settle();
    while (sb.pending_digits.size() != 0) @(posedge clk);
    repeat (5000) @(posedge clk);
  endtask

  task run_phase(int mode, int n, logic [61:0] ma, logic [61:0] mb, logic [5:0] b,
                 logic [6:0] l, logic crt);
    coef_t c;
    settle();
    idle_pct = 0; stall_pct = 0;
    set_config(ma, mb, b, l, crt);
    case (mode)
      1: idle_pct = 81;
      2: stall_pct = 81;
      3: begin idle_pct = 38; stall_pct = 38; end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      c.residue_a = pick_residue(ma);
      c.residue_b = pick_residue(mb);
      send_coef(c);
    end
    @(negedge clk) coef_valid <= 1'b0;
    phases++;
  endtask

  initial begin
    coef_t c;
    logic [61:0] pat[8];
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed words at reset settings (q = 2, 16-bit digits, 4 rows)
    pat = '{62'd0, 62'd1, 62'd2, 62'd3, MAX62[61:0], 62'h2AAAAAAAAAAAAAAA,
            62'h1555555555555555, 62'h0000FFFF8000FFFF};
    foreach (pat[i]) begin
      c.residue_a = pat[i];
      c.residue_b = ~pat[i];
      send_coef(c);
    end
    @(negedge clk) coef_valid <= 1'b0;

    // q at its top, one-bit digits, full 64 rows
    run_phase(0, 40, MAX62[61:0], 62'd5, 6'd1, 7'd64, 1'b0);
    // widest digits, single row
    run_phase(1, 45, rand62(), rand62(), 6'd63, 7'd1, 1'b0);
    // CRT with 63-bit digits reaching past the 128-bit edge
    run_phase(2, 45, rand62(), rand62(), 6'd63, 7'd3, 1'b1);
    // CRT at maximum moduli and rows; slow, so few words
    run_phase(3, 4, MAX62[61:0], MAX62[61:0], 6'd1, 7'd64, 1'b1);
    // zero modulus, zero digit width, count above the cap
    run_phase(0, 30, 62'd0, 62'd7, 6'd0, 7'd127, 1'b0);
    // zero count: no words out
    run_phase(1, 10, 62'd0, 62'($urandom_range(1000, 2)), 6'($urandom_range(20, 1)),
              7'd0, 1'b1);
    run_phase(2, 45, rand62(), rand62(), 6'($urandom_range(30, 2)),
              7'($urandom_range(16, 1)), 1'b0);
    run_phase(3, 45, rand62(), 62'd0, 6'($urandom_range(32, 8)),
              7'($urandom_range(8, 2)), 1'b1);
    run_phase(0, 45, 62'd2, 62'd3, 6'd2, 7'd8, 1'b1);
    run_phase(3, 45, 62'($urandom_range(100000, 3)), rand62(), 6'($urandom_range(12, 1)),
              7'($urandom_range(12, 1)), 1'b0);

    settle();
    $display("Sent %0d coefficients over %0d settings, checked %0d digit words.",
             sb.coefs, phases, sb.checked);
    $display("Covered single and CRT modes, digit widths 1..63, counts 0..64 and zero moduli.");
    if (sb.errors == 0 && sb.pending_digits.size() == 0) begin
      $display("rns_gadget_decompose verification clean");
    end else begin
      $display("rns_gadget_decompose verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== rns_gadget_decompose.f =====
src/rgd_pkg.sv
src/rgd_ram.sv
src/rgd_rem.sv
src/rgd_front.sv
src/rgd_engine.sv
src/rgd_emit.sv
src/rns_gadget_decompose.sv
tb/testbench.sv
